// ----- hw/rtl/kdsl_pkg.sv -----
// kdsl_pkg: shared types and constants for the key debounce short/long press block
// no dependencies
`default_nettype none

package kdsl_pkg;

  localparam int unsigned CountW   = 10;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned FlagW    = 4;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CountW-1:0] CountCap = CountW'(1000);

  localparam logic [CfgW-1:0] DebounceTicksRst = CfgW'(2);
  localparam logic [CfgW-1:0] ShortLimitRst    = CfgW'(50);
  localparam logic [CfgW-1:0] LongTicksRst     = CfgW'(100);

  localparam logic [KeyW-1:0] KeyNone  = KeyW'(0);
  localparam logic [KeyW-1:0] KeyDown  = KeyW'(1);
  localparam logic [KeyW-1:0] KeyUp    = KeyW'(2);
  localparam logic [KeyW-1:0] KeyMode  = KeyW'(3);
  localparam logic [KeyW-1:0] KeyPower = KeyW'(4);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_TICKS = 2'd0,
    CFG_SHORT_LIMIT    = 2'd1,
    CFG_LONG_TICKS     = 2'd2
  } cfg_idx_e;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            is_long;
  } event_t;

  function automatic logic [KeyW-1:0] pick_key(input logic [FlagW-1:0] flags);
    logic [KeyW-1:0] k;
    if (flags[0]) begin
      k = KeyDown;
    end else if (flags[1]) begin
      k = KeyUp;
    end else if (flags[2]) begin
      k = KeyMode;
    end else if (flags[3]) begin
      k = KeyPower;
    end else begin
      k = KeyNone;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/key_debounce_short_long_press_core.sv -----
// key_debounce_short_long_press_core: key debounce with short and long press events
// depends on kdsl_pkg
`default_nettype none

// usage
// input channel (in_valid_i / in_ready_o) carries one transaction per scan tick
// (cmd_i = tick, pressed_i = key flags) or per read (cmd_i = read)
// every input transaction yields exactly one output transaction
// (event_key_o / event_long_o); ticks report zero, a read reports the pending
// event and clears it
// the result of each input transaction is registered in the output buffer
// throughput: one transaction per cycle while in_ready_o is high; the state
// update is a single priority pick, one counter and a few 10-bit compares
// a two-entry output buffer (result register plus skid register) lets the
// block take a new transaction while a result waits; in_ready_o drops only
// when both entries are full, so a stalled receiver stops input after two
// results
// reset clears the phase, counters, pending event and output buffer and
// restores debounce_ticks 2, short_limit 50, long_ticks 100
// configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
// clock edge, index 3 is ignored
module key_debounce_short_long_press_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            cmd_i,
  input  wire  [kdsl_pkg::FlagW-1:0]     pressed_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [kdsl_pkg::KeyW-1:0]      event_key_o,
  output logic                           event_long_o,
  input  wire                            cfg_we_i,
  input  wire  [kdsl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [kdsl_pkg::CfgW-1:0]      cfg_data_i
);

  logic [kdsl_pkg::CfgW-1:0] debounce_ticks_q, short_limit_q, long_ticks_q;

  kdsl_pkg::phase_e            phase_q, phase_d;
  logic [kdsl_pkg::CountW-1:0] count_q, count_d;
  logic [kdsl_pkg::KeyW-1:0]   held_key_q, held_key_d;
  kdsl_pkg::event_t            pending_q, pending_d;

  kdsl_pkg::event_t            result;
  kdsl_pkg::event_t            main_q, main_d, skid_q, skid_d;
  logic                        main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;

  logic                        in_fire, out_fire;
  logic [kdsl_pkg::KeyW-1:0]   now_key;
  logic [kdsl_pkg::CountW:0]   count_inc;

  assign in_ready_o   = !skid_valid_q;
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = main_valid_q;
  assign out_fire     = main_valid_q && out_ready_i;
  assign event_key_o  = main_q.key;
  assign event_long_o = main_q.is_long;

  assign now_key   = kdsl_pkg::pick_key(pressed_i);
  assign count_inc = {1'b0, count_q} + (kdsl_pkg::CountW+1)'(1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= kdsl_pkg::DebounceTicksRst;
      short_limit_q    <= kdsl_pkg::ShortLimitRst;
      long_ticks_q     <= kdsl_pkg::LongTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kdsl_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i;
        kdsl_pkg::CFG_SHORT_LIMIT:    short_limit_q    <= cfg_data_i;
        kdsl_pkg::CFG_LONG_TICKS:     long_ticks_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // press state machine
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    held_key_d = held_key_q;
    pending_d  = pending_q;
    result     = '0;
    if (in_fire) begin
      if (cmd_i == kdsl_pkg::CMD_READ) begin
        result.key     = pending_q.key;
        result.is_long = (pending_q.key != kdsl_pkg::KeyNone) && pending_q.is_long;
        pending_d      = '0;
      end else begin
        unique case (phase_q)
          kdsl_pkg::PH_DEBOUNCE: begin
            if (now_key == held_key_q) begin
              count_d = count_inc[kdsl_pkg::CountW-1:0];
              if (count_inc >= {1'b0, debounce_ticks_q}) begin
                phase_d = kdsl_pkg::PH_HELD;
                count_d = '0;
              end
            end else begin
              phase_d = kdsl_pkg::PH_IDLE;
            end
          end
          kdsl_pkg::PH_HELD: begin
            if (now_key == kdsl_pkg::KeyNone) begin
              if (count_q < short_limit_q) begin
                pending_d.key     = held_key_q;
                pending_d.is_long = 1'b0;
              end
              phase_d = kdsl_pkg::PH_IDLE;
              count_d = '0;
            end else begin
              if (count_q == long_ticks_q) begin
                pending_d.key     = held_key_q;
                pending_d.is_long = 1'b1;
              end
              if (count_q >= kdsl_pkg::CountCap) begin
                count_d = kdsl_pkg::CountCap;
              end else begin
                count_d = count_inc[kdsl_pkg::CountW-1:0];
              end
            end
          end
          default: begin
            phase_d = kdsl_pkg::PH_IDLE;
            if (now_key != kdsl_pkg::KeyNone) begin
              held_key_d = now_key;
              count_d    = '0;
              phase_d    = kdsl_pkg::PH_DEBOUNCE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= kdsl_pkg::PH_IDLE;
      count_q    <= '0;
      held_key_q <= kdsl_pkg::KeyNone;
      pending_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      held_key_q <= held_key_d;
      pending_q  <= pending_d;
    end
  end

  // output buffer: result register plus skid register
  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_d       = result;
        skid_valid_d = in_fire;
      end else begin
        main_d       = result;
        main_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire
